// ===== hdl/rtp_frame_depacketizer_top_macros.svh =====
// ---------------------------------------------------------------------------
// RTP frame depacketizer assertion macros
// Shared concurrent assertion forms for the depacketizer RTL.
// ---------------------------------------------------------------------------
`ifndef RTP_FRAME_DEPACKETIZER_TOP_MACROS_SVH
`define RTP_FRAME_DEPACKETIZER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RFD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("depacketizer check failed");

// The consequent must hold in the cycle after the antecedent.
`define RFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("depacketizer check failed");

`endif

// ===== hdl/rfd_pkg.sv =====
// ---------------------------------------------------------------------------
// RTP frame depacketizer package
// Types and constants shared by the parser, queue and frame builder.
// ---------------------------------------------------------------------------
package rfd_pkg;

  localparam int HDR_BYTES  = 12;
  localparam int INDEX_W    = 12;
  localparam int HDR_W      = 13;
  localparam int START_W    = 19;
  localparam int OFFSET_W   = 19;
  localparam int LENGTH_W   = 20;
  localparam int PTS_W      = 64;
  localparam int TS_W       = 32;
  localparam int PT_W       = 7;

  localparam logic [INDEX_W-1:0] INDEX_MAX   = 12'd4095;
  localparam logic [1:0]         RTP_VERSION = 2'd2;
  localparam logic [PT_W-1:0]    PT_RESET    = 7'd96;
  localparam logic               REG_PAYLOAD_TYPE = 1'b0;

  typedef enum logic [1:0] {
    KIND_BYTE     = 2'd0,
    KIND_BYTE_END = 2'd1,
    KIND_END      = 2'd2,
    KIND_DROP     = 2'd3
  } rfd_kind_t;

  typedef enum logic [1:0] {
    RSN_NONE   = 2'd0,
    RSN_SHORT  = 2'd1,
    RSN_HEADER = 2'd2,
    RSN_TRUNC  = 2'd3
  } rfd_reason_t;

  typedef struct packed {
    logic [7:0]      data;
    logic            payload;
    logic            frame_end;
    rfd_reason_t     reason;
    logic [TS_W-1:0] ts_diff;
  } rfd_cmd_t;

endpackage

// ===== hdl/rfd_front.sv =====
// ---------------------------------------------------------------------------
// RTP header parser
// Tracks the byte position, decodes the fixed header, CSRC list and
// extension, and queues one command per payload byte or packet end.
// ---------------------------------------------------------------------------
module rfd_front
  import rfd_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic [PT_W-1:0] expected_pt,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [7:0]      in_tdata,
  input  logic            in_tlast,
  input  logic            q_full,
  output logic            q_push,
  output rfd_cmd_t        q_cmd
);

  logic [INDEX_W-1:0] pos_r, pos_nxt;
  logic [3:0]         csrc_r, csrc_nxt;
  logic               ext_r, ext_nxt;
  logic               marker_r, marker_nxt;
  logic               bad_r, bad_nxt;
  logic [7:0]         elh_r, elh_nxt;
  logic [START_W-1:0] pstart_r, pstart_nxt;
  logic [TS_W-1:0]    ts_r, ts_nxt;
  logic [TS_W-1:0]    prev_ts_r, prev_ts_nxt;

  logic [HDR_W-1:0]   hdr_end;
  logic [HDR_W-1:0]   len;
  logic               accept;
  logic               is_payload;
  rfd_reason_t        reason;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    hdr_end    = HDR_W'(HDR_BYTES) + {7'b0, csrc_r, 2'b00};
    len        = {1'b0, pos_r} + 13'd1;
    is_payload = !bad_r && ({7'b0, pos_r} >= pstart_r);

    if (len < HDR_W'(HDR_BYTES)) begin
      reason = RSN_SHORT;
    end else if (bad_r) begin
      reason = RSN_HEADER;
    end else if (hdr_end >= len) begin
      reason = RSN_TRUNC;
    end else if (ext_r && ((hdr_end + 13'd4 >= len) || (pstart_r > {6'b0, len}))) begin
      reason = RSN_TRUNC;
    end else begin
      reason = RSN_NONE;
    end

    pos_nxt     = pos_r;
    csrc_nxt    = csrc_r;
    ext_nxt     = ext_r;
    marker_nxt  = marker_r;
    bad_nxt     = bad_r;
    elh_nxt     = elh_r;
    pstart_nxt  = pstart_r;
    ts_nxt      = ts_r;
    prev_ts_nxt = prev_ts_r;

    q_cmd.data      = in_tdata;
    q_cmd.payload   = is_payload;
    q_cmd.frame_end = in_tlast && marker_r && (reason == RSN_NONE);
    q_cmd.reason    = in_tlast ? reason : RSN_NONE;
    q_cmd.ts_diff   = ts_r - prev_ts_r;
    q_push          = accept && (is_payload || in_tlast);

    if (accept) begin
      if (pos_r == '0) begin
        csrc_nxt   = in_tdata[3:0];
        ext_nxt    = in_tdata[4];
        bad_nxt    = (in_tdata[7:6] != RTP_VERSION);
        pstart_nxt = START_W'(HDR_BYTES) + {13'b0, in_tdata[3:0], 2'b00} +
                     (in_tdata[4] ? 19'd4 : 19'd0);
      end else if (pos_r == 12'd1) begin
        marker_nxt = in_tdata[7];
        if (in_tdata[6:0] != expected_pt) begin
          bad_nxt = 1'b1;
        end
      end else if (pos_r inside {[12'd4:12'd7]}) begin
        ts_nxt = {ts_r[TS_W-9:0], in_tdata};
      end

      if (ext_r) begin
        if ({1'b0, pos_r} == hdr_end + 13'd2) begin
          elh_nxt = in_tdata;
        end else if ({1'b0, pos_r} == hdr_end + 13'd3) begin
          pstart_nxt = START_W'(hdr_end) + 19'd4 + {1'b0, elh_r, in_tdata, 2'b00};
        end
      end

      if (in_tlast) begin
        if (q_cmd.frame_end) begin
          prev_ts_nxt = ts_r;
        end
        pos_nxt    = '0;
        csrc_nxt   = '0;
        ext_nxt    = 1'b0;
        marker_nxt = 1'b0;
        bad_nxt    = 1'b0;
        elh_nxt    = '0;
        pstart_nxt = START_W'(HDR_BYTES);
        ts_nxt     = '0;
      end else if (pos_r != INDEX_MAX) begin
        pos_nxt = pos_r + 12'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      csrc_r    <= '0;
      ext_r     <= 1'b0;
      marker_r  <= 1'b0;
      bad_r     <= 1'b0;
      elh_r     <= '0;
      pstart_r  <= START_W'(HDR_BYTES);
      ts_r      <= '0;
      prev_ts_r <= '0;
    end else begin
      pos_r     <= pos_nxt;
      csrc_r    <= csrc_nxt;
      ext_r     <= ext_nxt;
      marker_r  <= marker_nxt;
      bad_r     <= bad_nxt;
      elh_r     <= elh_nxt;
      pstart_r  <= pstart_nxt;
      ts_r      <= ts_nxt;
      prev_ts_r <= prev_ts_nxt;
    end
  end

endmodule

// ===== hdl/rfd_queue.sv =====
// ---------------------------------------------------------------------------
// RTP depacketizer command queue
// Small first-in first-out buffer between the parser and the frame builder.
// ---------------------------------------------------------------------------
module rfd_queue
  import rfd_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  rfd_cmd_t push_cmd,
  output logic     full,
  input  logic     pop,
  output logic     empty,
  output rfd_cmd_t pop_cmd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rfd_cmd_t           entry_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push;
  logic               do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== hdl/rfd_back.sv =====
// ---------------------------------------------------------------------------
// RTP frame builder
// Counts frame bytes against capacity, keeps the running PTS and drives the
// registered result beat.
// ---------------------------------------------------------------------------
module rfd_back
  import rfd_pkg::*;
#(
  parameter int FRAME_BYTES = 524288
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  input  rfd_cmd_t            cmd,
  output logic                cmd_pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output rfd_kind_t           out_kind,
  output logic [7:0]          out_byte,
  output logic [OFFSET_W-1:0] out_offset,
  output logic [LENGTH_W-1:0] out_length,
  output logic [PTS_W-1:0]    out_pts,
  output logic                out_overflow,
  output rfd_reason_t         out_reason
);

  localparam int FB_W = $clog2(FRAME_BYTES + 1);

  logic [FB_W-1:0]     fb_r, fb_nxt;
  logic                ovf_r, ovf_nxt;
  logic [PTS_W-1:0]    pts_r, pts_nxt;
  logic                valid_r, valid_nxt;
  rfd_kind_t           kind_r, kind_nxt;
  logic [7:0]          byte_r, byte_nxt;
  logic [OFFSET_W-1:0] offset_r, offset_nxt;
  logic [LENGTH_W-1:0] length_r, length_nxt;
  logic [PTS_W-1:0]    opts_r, opts_nxt;
  logic                oovf_r, oovf_nxt;
  rfd_reason_t         reason_r, reason_nxt;

  logic                room;
  logic                emit;
  logic [FB_W-1:0]     fb_inc;
  logic                ovf_after;

  assign cmd_pop = cmd_valid && (!valid_r || out_tready);

  always_comb begin
    room      = (fb_r < FB_W'(FRAME_BYTES));
    emit      = cmd.payload && room;
    fb_inc    = fb_r + FB_W'(emit);
    ovf_after = ovf_r || (cmd.payload && !room);

    fb_nxt     = fb_r;
    ovf_nxt    = ovf_r;
    pts_nxt    = pts_r;
    valid_nxt  = valid_r && !out_tready;
    kind_nxt   = kind_r;
    byte_nxt   = byte_r;
    offset_nxt = offset_r;
    length_nxt = length_r;
    opts_nxt   = opts_r;
    oovf_nxt   = oovf_r;
    reason_nxt = reason_r;

    if (cmd_pop) begin
      kind_nxt   = KIND_BYTE;
      byte_nxt   = emit ? cmd.data : 8'd0;
      offset_nxt = emit ? OFFSET_W'(fb_r) : '0;
      length_nxt = '0;
      opts_nxt   = '0;
      oovf_nxt   = 1'b0;
      reason_nxt = RSN_NONE;
      if (cmd.reason != RSN_NONE) begin
        fb_nxt     = fb_inc;
        ovf_nxt    = ovf_after;
        valid_nxt  = 1'b1;
        kind_nxt   = KIND_DROP;
        byte_nxt   = 8'd0;
        offset_nxt = '0;
        reason_nxt = cmd.reason;
      end else if (cmd.frame_end) begin
        pts_nxt    = pts_r + {32'b0, cmd.ts_diff};
        fb_nxt     = '0;
        ovf_nxt    = 1'b0;
        valid_nxt  = 1'b1;
        kind_nxt   = emit ? KIND_BYTE_END : KIND_END;
        length_nxt = LENGTH_W'(fb_inc);
        opts_nxt   = pts_r + {32'b0, cmd.ts_diff};
        oovf_nxt   = ovf_after;
      end else begin
        fb_nxt    = fb_inc;
        ovf_nxt   = ovf_after;
        valid_nxt = emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fb_r    <= '0;
      ovf_r   <= 1'b0;
      pts_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      fb_r    <= fb_nxt;
      ovf_r   <= ovf_nxt;
      pts_r   <= pts_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    byte_r   <= byte_nxt;
    offset_r <= offset_nxt;
    length_r <= length_nxt;
    opts_r   <= opts_nxt;
    oovf_r   <= oovf_nxt;
    reason_r <= reason_nxt;
  end

  assign out_tvalid   = valid_r;
  assign out_kind     = kind_r;
  assign out_byte     = byte_r;
  assign out_offset   = offset_r;
  assign out_length   = length_r;
  assign out_pts      = opts_r;
  assign out_overflow = oovf_r;
  assign out_reason   = reason_r;

endmodule

// ===== hdl/rtp_frame_depacketizer_top.sv =====
// ---------------------------------------------------------------------------
// RTP frame depacketizer
// Parses RTP packets arriving one byte per beat and emits framed payload.
// ---------------------------------------------------------------------------
// The block takes one packet byte per cycle while in_tready is high, with
// in_tlast on the final byte. The header parser decides in the accepting
// cycle, the command queue registers the command and hands it to the frame
// builder, and the builder's output register presents the result beat. The
// QUEUE_DEPTH-entry queue absorbs short output stalls; in_tready drops only
// when that queue is full. Payload bytes carry their offset within the frame,
// a marker packet closes the frame with its length and running 64-bit PTS,
// and a bad packet yields one drop beat on its final byte. No clearing pass
// follows reset.
`include "rtp_frame_depacketizer_top_macros.svh"

module rtp_frame_depacketizer_top
  import rfd_pkg::*;
#(
  parameter int FRAME_BYTES = 524288,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,    // [7:0] data_byte
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [119:0] out_tdata,   // [7:0] payload_byte, [26:8] frame_offset,
                                    // [46:27] frame_length, [110:47] frame_pts,
                                    // [111] frame_overflow, [113:112] drop_reason
  output logic [1:0]   out_tuser,   // [1:0] result_kind
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  logic [PT_W-1:0]     ept_r, ept_nxt;
  logic                q_push;
  logic                q_full;
  logic                q_pop;
  logic                q_empty;
  rfd_cmd_t            push_cmd;
  rfd_cmd_t            pop_cmd;
  rfd_kind_t           out_kind;
  logic [7:0]          out_byte;
  logic [OFFSET_W-1:0] out_offset;
  logic [LENGTH_W-1:0] out_length;
  logic [PTS_W-1:0]    out_pts;
  logic                out_overflow;
  rfd_reason_t         out_reason;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_PAYLOAD_TYPE) ? {25'b0, ept_r} : 32'b0;

  always_comb begin
    ept_nxt = ept_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
        (cfg_paddr[2] == REG_PAYLOAD_TYPE)) begin
      ept_nxt = cfg_pwdata[PT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ept_r <= PT_RESET;
    end else begin
      ept_r <= ept_nxt;
    end
  end

  rfd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .expected_pt (ept_r),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_cmd       (push_cmd)
  );

  rfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .pop_cmd  (pop_cmd)
  );

  rfd_back #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (!q_empty),
    .cmd          (pop_cmd),
    .cmd_pop      (q_pop),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_kind     (out_kind),
    .out_byte     (out_byte),
    .out_offset   (out_offset),
    .out_length   (out_length),
    .out_pts      (out_pts),
    .out_overflow (out_overflow),
    .out_reason   (out_reason)
  );

  assign out_tuser = out_kind;
  assign out_tdata = {6'b0, out_reason, out_overflow, out_pts, out_length,
                      out_offset, out_byte};

  `RFD_ASSERT_SAME(a_no_push_when_full, clk, rst_n, q_push, !q_full)
  `RFD_ASSERT_SAME(a_drop_has_reason, clk, rst_n,
    out_tvalid && (out_kind == KIND_DROP), out_reason != RSN_NONE)
  `RFD_ASSERT_SAME(a_byte_has_no_frame_info, clk, rst_n,
    out_tvalid && (out_kind == KIND_BYTE),
    (out_length == '0) && (out_pts == '0) && (out_reason == RSN_NONE))
  `RFD_ASSERT_NEXT(a_pop_refills_output, clk, rst_n,
    q_pop && pop_cmd.frame_end, out_tvalid)

endmodule
